### design/b64e_pkg.sv
package b64e_pkg;

    // ascii code of the padding character
    localparam logic [7:0] PadChar = 8'h3D;

    // characters one byte can produce
    localparam int MaxChars = 4;
    localparam int CharIdxW = $clog2(MaxChars);

    // entries in the queue between front and back
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // one decoded byte: its characters, index of the final one, end of message
    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        logic [CharIdxW-1:0]      last_idx;
        logic                     eom;
    } t_job;

    // six-bit symbol to base64 ascii character
    function automatic logic [7:0] sym(input logic [5:0] six);
        logic [7:0] code;
        code = 8'h2F;
        if (six < 6'd26) begin
            code = 8'h41 + 8'(six);
        end else if (six < 6'd52) begin
            code = 8'h61 + 8'(six - 6'd26);
        end else if (six < 6'd62) begin
            code = 8'h30 + 8'(six - 6'd52);
        end else if (six == 6'd62) begin
            code = 8'h2B;
        end
        return code;
    endfunction

endpackage

### design/b64e_if.sv
// raw byte channel
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// encoded character channel
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

### design/b64e_front.sv
module b64e_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    b64e_byte_if.sink       i_byte,
    input  logic            i_full,
    output logic            o_push,
    output b64e_pkg::t_job  o_job
);

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_left, n_left;
    logic [7:0] b;
    logic       eom;

    assign b      = i_byte.data_byte;
    assign eom    = i_byte.end_of_message;
    assign i_byte.ready = !i_full;
    assign o_push = i_byte.valid && !i_full;

    // split the byte into characters for the current group position
    always_comb begin
        o_job.chars    = '0;
        o_job.last_idx = '0;
        o_job.eom      = eom;
        n_phase        = PH_0;
        n_left         = '0;
        unique case (r_phase)
            PH_2: begin
                o_job.chars[0] = b64e_pkg::sym({r_left, b[7:6]});
                o_job.chars[1] = b64e_pkg::sym(b[5:0]);
                o_job.last_idx = b64e_pkg::CharIdxW'(1);
            end
            PH_1: begin
                o_job.chars[0] = b64e_pkg::sym({r_left[1:0], b[7:4]});
                if (eom) begin
                    o_job.chars[1] = b64e_pkg::sym({b[3:0], 2'b00});
                    o_job.chars[2] = b64e_pkg::PadChar;
                    o_job.last_idx = b64e_pkg::CharIdxW'(2);
                end else begin
                    n_phase = PH_2;
                    n_left  = b[3:0];
                end
            end
            default: begin
                // phase zero, and the unused code treated the same way
                o_job.chars[0] = b64e_pkg::sym(b[7:2]);
                if (eom) begin
                    o_job.chars[1] = b64e_pkg::sym({b[1:0], 4'b0000});
                    o_job.chars[2] = b64e_pkg::PadChar;
                    o_job.chars[3] = b64e_pkg::PadChar;
                    o_job.last_idx = b64e_pkg::CharIdxW'(3);
                end else begin
                    n_phase = PH_1;
                    n_left  = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    // group position and pending bits advance on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

### design/b64e_queue.sv
module b64e_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64e_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output b64e_pkg::t_job  o_job
);

    b64e_pkg::t_job                  r_mem [b64e_pkg::QueueDepth];
    logic [b64e_pkg::QueuePtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [b64e_pkg::QueueCntW-1:0]  r_count;

    assign o_full  = r_count == b64e_pkg::QueueCntW'(b64e_pkg::QueueDepth);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == b64e_pkg::QueuePtrW'(b64e_pkg::QueueDepth - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == b64e_pkg::QueuePtrW'(b64e_pkg::QueueDepth - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/b64e_back.sv
module b64e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  b64e_pkg::t_job  i_job,
    output logic            o_pop,
    b64e_char_if.source     o_char
);

    logic                          r_valid;
    logic [7:0]                    r_char;
    logic                          r_last;
    logic [b64e_pkg::CharIdxW-1:0] r_idx, n_idx;
    logic                          load;
    logic                          final_char;

    assign load       = !i_empty && (!r_valid || o_char.ready);
    assign final_char = r_idx == i_job.last_idx;
    assign o_pop      = load && final_char;
    assign n_idx      = final_char ? '0 : r_idx + 1'b1;

    assign o_char.valid     = r_valid;
    assign o_char.out_char  = r_char;
    assign o_char.last_char = r_last;

    // output register, one character per cycle from the head entry unless empty or stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (o_char.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // character payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_job.chars[r_idx];
            r_last <= final_char && i_job.eom;
        end
    end

endmodule

### design/base64_stream_encoder.sv
// streaming base64 encoder, standard alphabet with '=' padding
// i_byte: one raw byte per transaction; end_of_message marks the final byte
// of a message. o_char: one ascii character per transaction; last_char is
// set on the final character of the encoded message.
// each byte yields one character at group positions one and two, two at
// position three, and on the final byte the remaining bits plus padding:
// up to four characters in all.
// the first character of a byte passes through the queue and then the output
// register: the byte transaction writes the queue, and a load from the queue
// into the output register makes the character valid.
// the output register sends one character per cycle while the receiver is ready;
// a byte yields one to four characters, four characters per three bytes on a
// long message; a byte is taken every cycle while the two-entry queue has
// room.
// when the receiver stalls, the output character holds, the queue fills and
// i_byte.ready drops; nothing is lost.
// reset (synchronous, active low) empties the queue and the output register
// and returns the group position to the start of a message.
module base64_stream_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_byte_if.sink   i_byte,
    b64e_char_if.source o_char
);

    b64e_pkg::t_job push_job, head_job;
    logic           push, pop, full, empty;

    // byte classification
    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // decoupling queue
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    // character output
    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_char  (o_char)
    );

endmodule

### design/b64e_checker.sv
module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // a stalled character holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_last))
        else $error("stalled character changed");

    // nothing is offered right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("character valid after reset");

    // every character is from the alphabet or padding
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char >= 8'h41 && i_out_char <= 8'h5A)
            || (i_out_char >= 8'h61 && i_out_char <= 8'h7A)
            || (i_out_char >= 8'h30 && i_out_char <= 8'h39)
            || i_out_char == 8'h2B || i_out_char == 8'h2F || i_out_char == 8'h3D)
        else $error("character outside the base64 alphabet");

    // padding that is not the final character is followed by more padding
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_char == 8'h3D && !i_out_last
            |=> !i_out_valid || i_out_char == 8'h3D)
        else $error("padding followed by a symbol");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_char.valid),
    .i_out_ready (o_char.ready),
    .i_out_char  (o_char.out_char),
    .i_out_last  (o_char.last_char)
);

### tb/tb_base64_stream_encoder.sv
`timescale 1ns / 100ps

module tb_base64_stream_encoder;

    // generous bound: every byte at four characters, each one stalled, plus hold-offs
    localparam int unsigned CycleLimit = 300000;
    localparam int unsigned RandomBytes = 275;
    localparam int unsigned IdlePct = 31;

    // standard alphabet, index 0 in the top byte
    localparam logic [8*64-1:0] B64Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // position of the next byte within its three-byte group
    typedef enum logic [1:0] {
        GRP_FIRST  = 2'd0,
        GRP_SECOND = 2'd1,
        GRP_THIRD  = 2'd2,
        GRP_UNUSED = 2'd3
    } t_grp_pos;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_enc_char;

    logic i_clk;
    logic i_rst_n;

    b64e_byte_if byte_ch ();
    b64e_char_if char_ch ();

    base64_stream_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch.sink),
        .o_char  (char_ch.source)
    );

    // encoder state mirrored by the predictor
    t_grp_pos    grp_pos;
    logic [3:0]  grp_carry;
    t_enc_char   pending_chars[$];

    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned msgs_sent;
    int unsigned chars_checked;
    int unsigned cycle_count;
    bit          full_rate;
    int unsigned rx_hold_len;
    int unsigned rx_hold_cnt;

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // six-bit symbol to ascii
    function automatic logic [7:0] b64_code(input logic [5:0] six);
        return B64Alphabet[8*(63 - six) +: 8];
    endfunction

    function automatic void push_char(input logic [7:0] code, input logic last);
        t_enc_char c;
        c.code = code;
        c.last = last;
        pending_chars.push_back(c);
    endfunction

    // expected characters for one accepted byte, advances the group position
    function automatic void encode_byte(input logic [7:0] b, input logic eom);
        case (grp_pos)
            GRP_THIRD: begin
                push_char(b64_code({grp_carry, b[7:6]}), 1'b0);
                push_char(b64_code(b[5:0]), eom);
                grp_pos   = GRP_FIRST;
                grp_carry = '0;
            end
            GRP_SECOND: begin
                push_char(b64_code({grp_carry[1:0], b[7:4]}), 1'b0);
                if (eom) begin
                    push_char(b64_code({b[3:0], 2'b00}), 1'b0);
                    push_char(b64e_pkg::PadChar, 1'b1);
                    grp_pos   = GRP_FIRST;
                    grp_carry = '0;
                end else begin
                    grp_pos   = GRP_THIRD;
                    grp_carry = b[3:0];
                end
            end
            // first byte of a group; the unused position behaves the same
            default: begin
                push_char(b64_code(b[7:2]), 1'b0);
                if (eom) begin
                    push_char(b64_code({b[1:0], 4'b0000}), 1'b0);
                    push_char(b64e_pkg::PadChar, 1'b0);
                    push_char(b64e_pkg::PadChar, 1'b1);
                    grp_pos   = GRP_FIRST;
                    grp_carry = '0;
                end else begin
                    grp_pos   = GRP_SECOND;
                    grp_carry = {2'b00, b[1:0]};
                end
            end
        endcase
    endfunction

    // one byte transaction, with random idle cycles before it unless at full rate
    task automatic send_byte(input logic [7:0] b, input logic eom);
        if (!full_rate) begin
            while ($urandom_range(99) < IdlePct) begin
                byte_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        byte_ch.valid          <= 1'b1;
        byte_ch.data_byte      <= b;
        byte_ch.end_of_message <= eom;
        do @(posedge i_clk); while (!byte_ch.ready);
        encode_byte(b, eom);
        bytes_sent++;
        if (eom) msgs_sent++;
    endtask

    // message of random bytes, end flag on the last one
    task automatic send_message(input int unsigned len);
        for (int unsigned k = 1; k <= len; k++) begin
            send_byte(8'($urandom_range(255)), k == len);
        end
    endtask

    // mostly short messages, now and then a long one
    function automatic int unsigned pick_msg_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return $urandom_range(6, 1);
        if (roll < 95) return $urandom_range(20, 7);
        return $urandom_range(48, 21);
    endfunction

    // receiver: random stalls, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_len != 0) begin
            rx_hold_cnt = rx_hold_len;
            rx_hold_len = 0;
        end
        if (rx_hold_cnt != 0) begin
            rx_hold_cnt--;
            char_ch.ready <= 1'b0;
        end else begin
            char_ch.ready <= full_rate || ($urandom_range(99) >= IdlePct);
        end
    end

    // compare each character transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_enc_char want;
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character: out_char %h last_char %b",
                       char_ch.out_char, char_ch.last_char);
                error_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (char_ch.out_char !== want.code) begin
                    $error("out_char: expected %h, actual %h", want.code, char_ch.out_char);
                    error_count++;
                end
                if (char_ch.last_char !== want.last) begin
                    $error("last_char: expected %b, actual %b", want.last, char_ch.last_char);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, pending_chars.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // known vectors, all-zero and all-one bytes, every group position as the last
    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // "////"
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // "++++"
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        // "TWFu"
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        // second group ends after one byte
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b1);
        // "YWI="
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        // alternating bit patterns
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    // random messages with random stalls on both sides
    task automatic test_random_messages();
        int unsigned target;
        target = bytes_sent + RandomBytes;
        while (bytes_sent < target) begin
            send_message(pick_msg_len());
        end
    endtask

    // no idling on either side
    task automatic test_full_rate();
        int unsigned target;
        full_rate = 1'b1;
        target = bytes_sent + 60;
        while (bytes_sent < target) begin
            send_message(pick_msg_len());
        end
        full_rate = 1'b0;
    endtask

    // receiver holds off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        rx_hold_len = 150;
        for (int n = 0; n < 6; n++) begin
            send_message($urandom_range(5, 1));
        end
    endtask

    initial begin
        grp_pos       = GRP_FIRST;
        grp_carry     = '0;
        error_count   = 0;
        bytes_sent    = 0;
        msgs_sent     = 0;
        chars_checked = 0;
        cycle_count   = 0;
        full_rate     = 1'b0;
        rx_hold_len   = 0;
        rx_hold_cnt   = 0;

        i_rst_n                = 1'b0;
        byte_ch.valid          = 1'b0;
        byte_ch.data_byte      = '0;
        byte_ch.end_of_message = 1'b0;
        char_ch.ready          = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_rate();
        test_backpressure();
        test_random_messages();
        byte_ch.valid <= 1'b0;

        // drain outstanding characters, then a few quiet cycles
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("encoded %0d bytes in %0d messages, %0d characters checked",
                 bytes_sent, msgs_sent, chars_checked);
        $display("directed vectors, full rate, long receiver hold-off and random stalls");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
